>>> rtl/qrp_pkg.sv
// shared widths, types and register codes for the quaternion point rotation core
// no dependencies; imported by quaternion_rotate_point_core and tb_top
package qrp_pkg;

  localparam int COORD_BITS     = 24;
  localparam int QUAT_FRAC_BITS = 14;
  localparam int Q_W            = 16;
  localparam int ADDR_W         = 4;
  localparam int DATA_W         = 32;
  localparam int NUM_REGS       = 4;

  localparam int P1_W = Q_W + COORD_BITS;
  localparam int S1_W = P1_W + 3;
  localparam int H1_W = S1_W - QUAT_FRAC_BITS;
  localparam int T_W  = COORD_BITS + 3;
  localparam int P2_W = T_W + Q_W;
  localparam int S2_W = P2_W + 3;
  localparam int H2_W = S2_W - QUAT_FRAC_BITS;
  localparam int IDX_W = $clog2(NUM_REGS);

  typedef logic signed [Q_W-1:0]        q_word_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [P1_W-1:0]       p1_t;
  typedef logic signed [S1_W-1:0]       s1_t;
  typedef logic signed [H1_W-1:0]       h1_t;
  typedef logic signed [T_W-1:0]        tval_t;
  typedef logic signed [P2_W-1:0]       p2_t;
  typedef logic signed [S2_W-1:0]       s2_t;
  typedef logic signed [H2_W-1:0]       h2_t;

  typedef enum logic [IDX_W-1:0] {
    REG_ROT_W = IDX_W'(0),
    REG_ROT_X = IDX_W'(1),
    REG_ROT_Y = IDX_W'(2),
    REG_ROT_Z = IDX_W'(3)
  } reg_idx_t;

  localparam q_word_t ROT_W_RESET = Q_W'(2 ** QUAT_FRAC_BITS);
  localparam s1_t     RND1        = S1_W'(2 ** (QUAT_FRAC_BITS - 1));
  localparam s2_t     RND2        = S2_W'(2 ** (QUAT_FRAC_BITS - 1));

endpackage

>>> rtl/quaternion_rotate_point_core.sv
// quaternion point rotation and quaternion product, four-stage pipeline
// depends on qrp_pkg
//
// Takes one beat per clock when the output is not stalled and returns one result beat
// per input beat. The rate is set by two banks of sixteen multipliers (the q*p product,
// then the product with conj(q)), each followed by a register; every stage holds its
// own valid bit, so bubbles close up and a stalled output still lets earlier stages
// fill. The rotation quaternion lives in four APB registers (signed Q1.14, reset to
// identity) and must be written by the user only while no beat is in flight; the block
// does not enforce it. Mode 0 rotates (in_x, in_y, in_z); mode 1 returns q * (in_w..in_z).
module quaternion_rotate_point_core
  import qrp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  coord_t            in_w,
  input  coord_t            in_x,
  input  coord_t            in_y,
  input  coord_t            in_z,
  output logic              out_valid,
  input  logic              out_ready,
  output coord_t            out_w,
  output coord_t            out_x,
  output coord_t            out_y,
  output coord_t            out_z,
  output logic              saturated
);

  q_word_t  rq [NUM_REGS];
  reg_idx_t widx;

  logic rdy1, rdy2, rdy3, rdy4;
  logic v1, v2, v3;

  coord_t b [4];
  p1_t    p1_next [4][4];
  p1_t    p1 [4][4];
  logic   mode1;

  s1_t    s1 [4];
  h1_t    h1 [4];
  tval_t  t_next [4];
  logic   flag2_next;
  tval_t  t [4];
  logic   mode2, flag2;

  p2_t    p2_next [4][4];
  p2_t    p2 [4][4];
  tval_t  tp [4];
  logic   mode3, flag3;

  s2_t    s2 [4];
  h2_t    h2 [4];
  coord_t r_next [4];
  logic   flag4_next;

  // register port
  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign prdata = DATA_W'(rq[paddr[ADDR_W-1:2]]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rq[REG_ROT_W] <= ROT_W_RESET;
      rq[REG_ROT_X] <= '0;
      rq[REG_ROT_Y] <= '0;
      rq[REG_ROT_Z] <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        REG_ROT_W: rq[REG_ROT_W] <= pwdata[Q_W-1:0];
        REG_ROT_X: rq[REG_ROT_X] <= pwdata[Q_W-1:0];
        REG_ROT_Y: rq[REG_ROT_Y] <= pwdata[Q_W-1:0];
        REG_ROT_Z: rq[REG_ROT_Z] <= pwdata[Q_W-1:0];
        default: ;
      endcase
    end
  end

  // per-stage flow control
  assign rdy4     = !out_valid || out_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) out_valid <= v3;
    end
  end

  // stage 1: q times input
  always_comb begin
    b[0] = mode ? in_w : '0;
    b[1] = in_x;
    b[2] = in_y;
    b[3] = in_z;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p1_next[i][j] = p1_t'(rq[i]) * p1_t'(b[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      p1    <= p1_next;
      mode1 <= mode;
    end
  end

  // stage 2: sum, round, clip
  always_comb begin
    s1[0] = s1_t'(p1[0][0]) - s1_t'(p1[1][1]) - s1_t'(p1[2][2]) - s1_t'(p1[3][3]) + RND1;
    s1[1] = s1_t'(p1[0][1]) + s1_t'(p1[1][0]) + s1_t'(p1[2][3]) - s1_t'(p1[3][2]) + RND1;
    s1[2] = s1_t'(p1[0][2]) - s1_t'(p1[1][3]) + s1_t'(p1[2][0]) + s1_t'(p1[3][1]) + RND1;
    s1[3] = s1_t'(p1[0][3]) + s1_t'(p1[1][2]) - s1_t'(p1[2][1]) + s1_t'(p1[3][0]) + RND1;
    flag2_next = 1'b0;
    for (int k = 0; k < 4; k++) begin
      h1[k] = s1[k][S1_W-1:QUAT_FRAC_BITS];
      if (mode1) begin
        if ((&h1[k][H1_W-1:COORD_BITS-1]) || !(|h1[k][H1_W-1:COORD_BITS-1])) begin
          t_next[k] = T_W'($signed(h1[k][COORD_BITS-1:0]));
        end else begin
          t_next[k]  = T_W'($signed({h1[k][H1_W-1], {(COORD_BITS-1){~h1[k][H1_W-1]}}}));
          flag2_next = 1'b1;
        end
      end else begin
        if ((&h1[k][H1_W-1:T_W-1]) || !(|h1[k][H1_W-1:T_W-1])) begin
          t_next[k] = h1[k][T_W-1:0];
        end else begin
          t_next[k]  = {h1[k][H1_W-1], {(T_W-1){~h1[k][H1_W-1]}}};
          flag2_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      t     <= t_next;
      mode2 <= mode1;
      flag2 <= flag2_next;
    end
  end

  // stage 3: intermediate times q, conjugate signs folded into the sums
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p2_next[i][j] = p2_t'(t[i]) * p2_t'(rq[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      p2    <= p2_next;
      tp    <= t;
      mode3 <= mode2;
      flag3 <= flag2;
    end
  end

  // stage 4: sum, round, final clip (mode 1 passes the stage 2 result), output register
  always_comb begin
    s2[0] = s2_t'(p2[0][0]) + s2_t'(p2[1][1]) + s2_t'(p2[2][2]) + s2_t'(p2[3][3]) + RND2;
    s2[1] = s2_t'(p2[1][0]) - s2_t'(p2[0][1]) - s2_t'(p2[2][3]) + s2_t'(p2[3][2]) + RND2;
    s2[2] = s2_t'(p2[2][0]) - s2_t'(p2[0][2]) + s2_t'(p2[1][3]) - s2_t'(p2[3][1]) + RND2;
    s2[3] = s2_t'(p2[3][0]) - s2_t'(p2[0][3]) - s2_t'(p2[1][2]) + s2_t'(p2[2][1]) + RND2;
    flag4_next = flag3;
    for (int k = 0; k < 4; k++) begin
      h2[k] = s2[k][S2_W-1:QUAT_FRAC_BITS];
      if (mode3) begin
        r_next[k] = tp[k][COORD_BITS-1:0];
      end else if ((&h2[k][H2_W-1:COORD_BITS-1]) || !(|h2[k][H2_W-1:COORD_BITS-1])) begin
        r_next[k] = h2[k][COORD_BITS-1:0];
      end else begin
        r_next[k]  = {h2[k][H2_W-1], {(COORD_BITS-1){~h2[k][H2_W-1]}}};
        flag4_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      out_w     <= r_next[0];
      out_x     <= r_next[1];
      out_y     <= r_next[2];
      out_z     <= r_next[3];
      saturated <= flag4_next;
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// testbench for quaternion_rotate_point_core: point rotation and quaternion product
// self-checking against an in-bench fixed-point predictor; depends on qrp_pkg and the core
module tb_top;
  import qrp_pkg::*;

  localparam logic MODE_ROTATE  = 1'b0;
  localparam logic MODE_PRODUCT = 1'b1;
  localparam coord_t CMAX = coord_t'(24'sh7FFFFF);
  localparam coord_t CMIN = coord_t'(24'sh800000);
  localparam int PHASE_BEATS = 116;
  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic   mode;
    coord_t w;
    coord_t x;
    coord_t y;
    coord_t z;
  } beat_t;

  typedef struct packed {
    coord_t w;
    coord_t x;
    coord_t y;
    coord_t z;
    logic   sat;
  } rot_result_t;

  typedef struct packed {
    logic        cfg;
    reg_idx_t    ridx;
    q_word_t     rval;
    beat_t       beat;
    logic        typed;
    rot_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  coord_t in_w = '0;
  coord_t in_x = '0;
  coord_t in_y = '0;
  coord_t in_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  coord_t out_w;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  logic saturated;

  q_word_t rot_q [NUM_REGS];
  rot_result_t rotated_q[$];
  int errors = 0;
  int cycles = 0;
  int gap_pct = 37;
  int stall_pct = 37;
  bit hold_req = 1'b0;
  int hold_left = 0;

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    // identity quaternion after reset: output equals input, with w zero in rotate mode
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_ROTATE, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
      1'b1, '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_ROTATE, CMAX, CMAX, CMIN, -24'sd1},
      1'b1, '{24'sd0, CMAX, CMIN, -24'sd1, 1'b0}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_ROTATE, CMIN, CMIN, CMAX, 24'sd1},
      1'b1, '{24'sd0, CMIN, CMAX, 24'sd1, 1'b0}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_PRODUCT, CMAX, CMAX, CMAX, CMAX},
      1'b1, '{CMAX, CMAX, CMAX, CMAX, 1'b0}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_PRODUCT, CMIN, CMIN, CMIN, CMIN},
      1'b1, '{CMIN, CMIN, CMIN, CMIN, 1'b0}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_PRODUCT, 24'sd1, -24'sd1, 24'sd12345, -24'sd54321},
      1'b1, '{24'sd1, -24'sd1, 24'sd12345, -24'sd54321, 1'b0}},
    // scalar -2.0: products are negated and doubled, rotations scaled by four; large values saturate
    '{1'b1, REG_ROT_W, -16'sd32768, '{MODE_ROTATE, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
      1'b0, '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_PRODUCT, CMIN, CMIN, CMIN, CMIN},
      1'b1, '{CMAX, CMAX, CMAX, CMAX, 1'b1}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_PRODUCT, CMAX, CMAX, CMAX, CMAX},
      1'b1, '{CMIN, CMIN, CMIN, CMIN, 1'b1}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_PRODUCT, 24'sd1, 24'sd2, -24'sd3, 24'sd4},
      1'b1, '{-24'sd2, -24'sd4, 24'sd6, -24'sd8, 1'b0}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_ROTATE, 24'sd0, 24'sd1, -24'sd1, 24'sd1000},
      1'b1, '{24'sd0, 24'sd4, -24'sd4, 24'sd4000, 1'b0}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_ROTATE, 24'sd0, CMAX, 24'sd0, CMIN},
      1'b1, '{24'sd0, CMAX, 24'sd0, CMIN, 1'b1}},
    // half turn about x
    '{1'b1, REG_ROT_W, 16'sd0, '{MODE_ROTATE, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
      1'b0, '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}},
    '{1'b1, REG_ROT_X, 16'sd16384, '{MODE_ROTATE, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
      1'b0, '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_ROTATE, 24'sd0, 24'sd5, 24'sd6, 24'sd7},
      1'b1, '{24'sd0, 24'sd5, -24'sd6, -24'sd7, 1'b0}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_ROTATE, 24'sd0, CMIN, CMIN, CMIN},
      1'b1, '{24'sd0, CMIN, CMAX, CMAX, 1'b1}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_PRODUCT, 24'sd1, 24'sd2, 24'sd3, 24'sd4},
      1'b1, '{-24'sd2, 24'sd1, -24'sd4, 24'sd3, 1'b0}},
    // largest positive y part and most negative z part, x kept from the half turn
    '{1'b1, REG_ROT_Y, 16'sd32767, '{MODE_ROTATE, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
      1'b0, '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}},
    '{1'b1, REG_ROT_Z, -16'sd32768, '{MODE_ROTATE, 24'sd0, 24'sd0, 24'sd0, 24'sd0},
      1'b0, '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_ROTATE, CMAX, CMAX, CMIN, CMAX},
      1'b0, '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}},
    '{1'b0, REG_ROT_W, 16'sd0, '{MODE_PRODUCT, CMIN, CMAX, CMIN, CMAX},
      1'b0, '{24'sd0, 24'sd0, 24'sd0, 24'sd0, 1'b0}}
  };

  quaternion_rotate_point_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode),
    .in_w(in_w), .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_w(out_w), .out_x(out_x), .out_y(out_y), .out_z(out_z),
    .saturated(saturated)
  );

  always #2 clk = ~clk;

  function automatic longint round_q(longint s);
    return (s + (longint'(1) <<< (QUAT_FRAC_BITS - 1))) >>> QUAT_FRAC_BITS;
  endfunction

  function automatic longint clamp_bits(longint v, int bits, inout logic flag);
    longint hi;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    if (v > hi) begin
      flag = 1'b1;
      return hi;
    end
    if (v < -hi - 1) begin
      flag = 1'b1;
      return -hi - 1;
    end
    return v;
  endfunction

  function automatic void hamilton(input longint a[4], input longint b[4],
                                   output longint r[4]);
    r[0] = round_q(a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3]);
    r[1] = round_q(a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2]);
    r[2] = round_q(a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1]);
    r[3] = round_q(a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0]);
  endfunction

  function automatic rot_result_t rotate_predict(beat_t b);
    longint q [4];
    longint p [4];
    longint t [4];
    longint c [4];
    longint r [4];
    logic flag;
    rot_result_t o;
    flag = 1'b0;
    for (int i = 0; i < 4; i++) q[i] = rot_q[i];
    p[0] = b.w;
    p[1] = b.x;
    p[2] = b.y;
    p[3] = b.z;
    if (b.mode == MODE_ROTATE) begin
      p[0] = 0;
      hamilton(q, p, t);
      for (int i = 0; i < 4; i++) t[i] = clamp_bits(t[i], T_W, flag);
      c[0] = q[0];
      for (int i = 1; i < 4; i++) c[i] = -q[i];
      hamilton(t, c, r);
    end else begin
      hamilton(q, p, r);
    end
    for (int i = 0; i < 4; i++) r[i] = clamp_bits(r[i], COORD_BITS, flag);
    o.w = coord_t'(r[0]);
    o.x = coord_t'(r[1]);
    o.y = coord_t'(r[2]);
    o.z = coord_t'(r[3]);
    o.sat = flag;
    return o;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(9))
      0: return CMAX;
      1: return CMIN;
      2: return '0;
      3: return coord_t'(int'($urandom_range(255)) - 128);
      default: return coord_t'($urandom());
    endcase
  endfunction

  task automatic reg_write(reg_idx_t idx, q_word_t val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= DATA_W'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rot_q[idx] = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[Q_W-1:0] !== val) begin
      $error("%s readback: expected %0d, got %0d", idx.name(), val,
             $signed(prdata[Q_W-1:0]));
      errors++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_beat(beat_t b, rot_result_t e);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode <= b.mode;
    in_w <= b.w;
    in_x <= b.x;
    in_y <= b.y;
    in_z <= b.z;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rotated_q.push_back(e);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (rotated_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // receiver: random stalls plus a long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    rot_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (rotated_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = rotated_q.pop_front();
        if (out_w !== e.w) begin
          $error("out_w: expected %0d, got %0d", e.w, out_w);
          errors++;
        end
        if (out_x !== e.x) begin
          $error("out_x: expected %0d, got %0d", e.x, out_x);
          errors++;
        end
        if (out_y !== e.y) begin
          $error("out_y: expected %0d, got %0d", e.y, out_y);
          errors++;
        end
        if (out_z !== e.z) begin
          $error("out_z: expected %0d, got %0d", e.z, out_z);
          errors++;
        end
        if (saturated !== e.sat) begin
          $error("saturated: expected %0d, got %0d", e.sat, saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    beat_t b;
    q_word_t qv [NUM_REGS];
    rot_q[REG_ROT_W] = ROT_W_RESET;
    rot_q[REG_ROT_X] = '0;
    rot_q[REG_ROT_Y] = '0;
    rot_q[REG_ROT_Z] = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].cfg) begin
        wait_idle();
        reg_write(DIR_TAB[i].ridx, DIR_TAB[i].rval);
      end else if (DIR_TAB[i].typed) begin
        send_beat(DIR_TAB[i].beat, DIR_TAB[i].res);
      end else begin
        send_beat(DIR_TAB[i].beat, rotate_predict(DIR_TAB[i].beat));
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      wait_idle();
      case (ph)
        0: qv = '{ROT_W_RESET, 16'sd0, 16'sd0, 16'sd0};
        1: qv = '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
        2: qv = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
        3: qv = '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768};
        4: qv = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
        5: qv = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767};
        default: for (int r = 0; r < NUM_REGS; r++) qv[r] = q_word_t'($urandom());
      endcase
      reg_write(REG_ROT_W, qv[0]);
      reg_write(REG_ROT_X, qv[1]);
      reg_write(REG_ROT_Y, qv[2]);
      reg_write(REG_ROT_Z, qv[3]);
      gap_pct = (ph == 2) ? 0 : 37;
      stall_pct = (ph == 2) ? 0 : 37;
      if (ph == 3 || ph == 6) hold_req = 1'b1;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        b.mode = 1'($urandom_range(1));
        b.w = rand_coord();
        b.x = rand_coord();
        b.y = rand_coord();
        b.z = rand_coord();
        send_beat(b, rotate_predict(b));
      end
    end

    wait_idle();
    repeat (16) @(posedge clk);
    if (rotated_q.size() != 0) begin
      $error("%0d expected results never arrived", rotated_q.size());
      errors++;
    end
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/qrp_pkg.sv
rtl/quaternion_rotate_point_core.sv
test/tb_top.sv
